FILE: hdl/pts_pkg.sv
`default_nettype none
package pts_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
        logic       empty_string;
    } item_t;

    typedef struct packed {
        logic       path_rejected;
        logic [2:0] reject_reason;
    } verdict_t;

    typedef enum logic [2:0] {
        REASON_OK            = 3'd0,
        REASON_EMPTY         = 3'd1,
        REASON_DOTDOT_SLASH  = 3'd2,
        REASON_TRAILING      = 3'd3,
        REASON_DOTDOT_BSLASH = 3'd4,
        REASON_ENCODED       = 3'd5,
        REASON_NULL          = 3'd6
    } reason_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_FIVE    = 8'h35;
    localparam logic [7:0] CH_LC_C    = 8'h63;
    localparam logic [7:0] CH_LC_E    = 8'h65;
    localparam logic [7:0] CH_LC_F    = 8'h66;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    localparam logic [2:0] MAX_REASON = 3'd6;

    // letter match in either case
    function automatic logic letter_eq(input logic [7:0] c, input logic [7:0] lc);
        letter_eq = (c == lc) || (c == (lc - CASE_DELTA));
    endfunction

endpackage
`default_nettype wire

FILE: hdl/path_traversal_screen.sv
// Path traversal screen.
// Item channel (item_valid/item_ready/item): one path byte per transaction,
// last_byte marks the end of a string, empty_string marks a zero-length string.
// Verdict channel (verdict_valid/verdict_ready/verdict): one transaction per
// string, carrying path_rejected and reject_reason.
// Throughput: one item per cycle, sustained, while verdicts are taken.
// A final byte passes through the input register, then the screening logic
// into the verdict register, where its verdict becomes valid. Bytes that do
// not end a string produce no transaction.
// Reset clears the byte history, position count, hit flags and the valid
// flags of both pipeline registers; no transaction is pending afterwards.
// When the receiver stalls, the verdict register holds its transaction.
// Bytes that do not end a string keep flowing; a second final byte waits in
// the input register, and item_ready drops only while that register is
// occupied and cannot drain.
`default_nettype none
module path_traversal_screen
    import pts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire item_t    item,
    output logic          verdict_valid,
    input  wire logic     verdict_ready,
    output verdict_t      verdict
);

    item_t    item_reg;
    logic     stage_valid_reg, stage_valid_next;
    logic     out_valid_reg, out_valid_next;
    verdict_t out_reg;

    logic     advance;
    logic     due;
    verdict_t screened;

    pts_screen u_screen (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (item_reg),
        .due     (due),
        .verdict (screened)
    );

    always_comb
    begin
        advance          = stage_valid_reg && (!due || !out_valid_reg || verdict_ready);
        item_ready       = !stage_valid_reg || advance;
        stage_valid_next = item_valid || (stage_valid_reg && !advance);
        if (!item_ready)
            stage_valid_next = stage_valid_reg;
        if (advance && due)
            out_valid_next = 1'b1;
        else if (verdict_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (advance && due)
            out_reg <= screened;
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_reg;

endmodule
`default_nettype wire

FILE: hdl/pts_screen.sv
`default_nettype none
module pts_screen
    import pts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire item_t    item,
    output logic          due,
    output verdict_t      verdict
);

    logic [31:0] recent_reg, recent_next;
    logic [1:0]  pos_reg, pos_next;
    logic        ds_hit_reg, ds_hit_next;
    logic        db_hit_reg, db_hit_next;
    logic        enc_hit_reg, enc_hit_next;
    logic        nul_hit_reg, nul_hit_next;

    logic [7:0] c, p1, p2, p3, p4;
    logic       two;
    logic       ds_now, db_now, enc_now, nul_now, trailing;
    logic       ds_all, db_all, enc_all, nul_all;
    reason_t    reason;

    always_comb
    begin
        c   = item.char_byte;
        p1  = recent_reg[7:0];
        p2  = recent_reg[15:8];
        p3  = recent_reg[23:16];
        p4  = recent_reg[31:24];
        two = pos_reg[1];

        ds_now = two && (c == CH_SLASH) && (p1 == CH_DOT) && (p2 == CH_DOT)
                 && ((pos_reg == 2'd2) || (p3 == CH_SLASH));
        db_now = two && (c == CH_BSLASH) && (p1 == CH_DOT) && (p2 == CH_DOT);
        enc_now = (two && (p2 == CH_PERCENT)
                   && (((p1 == CH_TWO) && (letter_eq(c, CH_LC_F) || letter_eq(c, CH_LC_E)))
                       || ((p1 == CH_FIVE) && letter_eq(c, CH_LC_C))))
                  || ((p4 == CH_PERCENT) && (p3 == CH_TWO) && (p2 == CH_FIVE)
                   && (((p1 == CH_TWO) && (letter_eq(c, CH_LC_E) || letter_eq(c, CH_LC_F)))
                       || ((p1 == CH_FIVE) && letter_eq(c, CH_LC_C))));
        nul_now = (c == CH_NUL)
                  || (two && (p2 == CH_PERCENT) && (p1 == CH_ZERO) && (c == CH_ZERO));
        trailing = two && (p2 == CH_SLASH) && (p1 == CH_DOT) && (c == CH_DOT);

        ds_all  = ds_hit_reg | ds_now;
        db_all  = db_hit_reg | db_now;
        enc_all = enc_hit_reg | enc_now;
        nul_all = nul_hit_reg | nul_now;

        if (item.empty_string)
            reason = REASON_EMPTY;
        else if (ds_all)
            reason = REASON_DOTDOT_SLASH;
        else if (trailing)
            reason = REASON_TRAILING;
        else if (db_all)
            reason = REASON_DOTDOT_BSLASH;
        else if (enc_all)
            reason = REASON_ENCODED;
        else if (nul_all)
            reason = REASON_NULL;
        else
            reason = REASON_OK;

        due                   = item.empty_string | item.last_byte;
        verdict.reject_reason = reason;
        verdict.path_rejected = (reason != REASON_OK);
    end

    always_comb
    begin
        recent_next  = recent_reg;
        pos_next     = pos_reg;
        ds_hit_next  = ds_hit_reg;
        db_hit_next  = db_hit_reg;
        enc_hit_next = enc_hit_reg;
        nul_hit_next = nul_hit_reg;
        if (step)
        begin
            if (due)
            begin
                recent_next  = '0;
                pos_next     = '0;
                ds_hit_next  = 1'b0;
                db_hit_next  = 1'b0;
                enc_hit_next = 1'b0;
                nul_hit_next = 1'b0;
            end
            else
            begin
                recent_next  = {recent_reg[23:0], c};
                pos_next     = (pos_reg == 2'd3) ? pos_reg : pos_reg + 2'd1;
                ds_hit_next  = ds_all;
                db_hit_next  = db_all;
                enc_hit_next = enc_all;
                nul_hit_next = nul_all;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg  <= '0;
            pos_reg     <= '0;
            ds_hit_reg  <= 1'b0;
            db_hit_reg  <= 1'b0;
            enc_hit_reg <= 1'b0;
            nul_hit_reg <= 1'b0;
        end
        else
        begin
            recent_reg  <= recent_next;
            pos_reg     <= pos_next;
            ds_hit_reg  <= ds_hit_next;
            db_hit_reg  <= db_hit_next;
            enc_hit_reg <= enc_hit_next;
            nul_hit_reg <= nul_hit_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pts_checker.sv
`default_nettype none
module pts_checker
    import pts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    input  wire logic     item_ready,
    input  wire item_t    item,
    input  wire logic     verdict_valid,
    input  wire logic     verdict_ready,
    input  wire verdict_t verdict
);

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item dropped or changed while waiting");

    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict))
        else $error("verdict dropped or changed while stalled");

    a_flag_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict.path_rejected == (verdict.reject_reason != REASON_OK)))
        else $error("reject flag disagrees with reason");

    a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict.reject_reason <= MAX_REASON))
        else $error("reason code out of range");

    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && verdict_ready |-> item_ready)
        else $error("input stalled while verdict drains");

endmodule

bind path_traversal_screen pts_checker u_pts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench
    import pts_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1625;

    class traversal_screen_model;
        logic [31:0] history;
        logic [1:0]  seen;
        bit          slash_hit;
        bit          bslash_hit;
        bit          enc_hit;
        bit          nul_hit;
        reason_t     expected_reasons[$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            history    = '0;
            seen       = '0;
            slash_hit  = 1'b0;
            bslash_hit = 1'b0;
            enc_hit    = 1'b0;
            nul_hit    = 1'b0;
        endfunction

        function bit folds_to(logic [7:0] c, logic [7:0] lc);
            return (c | CASE_DELTA) == lc;
        endfunction

        // tail of %2e, %2f or %5c, in either letter case
        function bit encoded_tail(logic [7:0] p1, logic [7:0] c);
            return (p1 == CH_TWO && (folds_to(c, CH_LC_F) || folds_to(c, CH_LC_E))) ||
                   (p1 == CH_FIVE && folds_to(c, CH_LC_C));
        endfunction

        function int pending();
            return expected_reasons.size();
        endfunction

        function void absorb_item(item_t it);
            logic [7:0] c;
            logic [7:0] p1;
            logic [7:0] p2;
            logic [7:0] p3;
            logic [7:0] p4;
            bit         two;
            bit         trailing;
            reason_t    r;
            if (it.empty_string)
            begin
                clear();
                expected_reasons.push_back(REASON_EMPTY);
                return;
            end
            c   = it.char_byte;
            p1  = history[7:0];
            p2  = history[15:8];
            p3  = history[23:16];
            p4  = history[31:24];
            two = seen >= 2'd2;
            if (two && c == CH_SLASH && p1 == CH_DOT && p2 == CH_DOT &&
                (seen == 2'd2 || p3 == CH_SLASH))
                slash_hit = 1'b1;
            if (two && c == CH_BSLASH && p1 == CH_DOT && p2 == CH_DOT)
                bslash_hit = 1'b1;
            if (two && p2 == CH_PERCENT && encoded_tail(p1, c))
                enc_hit = 1'b1;
            if (p4 == CH_PERCENT && p3 == CH_TWO && p2 == CH_FIVE && encoded_tail(p1, c))
                enc_hit = 1'b1;
            if (c == CH_NUL || (two && p2 == CH_PERCENT && p1 == CH_ZERO && c == CH_ZERO))
                nul_hit = 1'b1;
            trailing = two && p2 == CH_SLASH && p1 == CH_DOT && c == CH_DOT;
            history = {history[23:0], c};
            if (seen != 2'd3)
                seen = seen + 2'd1;
            if (!it.last_byte)
                return;
            if (slash_hit)
                r = REASON_DOTDOT_SLASH;
            else if (trailing)
                r = REASON_TRAILING;
            else if (bslash_hit)
                r = REASON_DOTDOT_BSLASH;
            else if (enc_hit)
                r = REASON_ENCODED;
            else if (nul_hit)
                r = REASON_NULL;
            else
                r = REASON_OK;
            clear();
            expected_reasons.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("verdict mismatch (%s): got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task compare_verdict(verdict_t v);
            reason_t want;
            if (expected_reasons.size() == 0)
            begin
                report("no verdict outstanding", v.reject_reason, 0);
                return;
            end
            want = expected_reasons.pop_front();
            if (v.path_rejected !== (want != REASON_OK))
                report("path_rejected", v.path_rejected, want != REASON_OK);
            if (v.reject_reason !== want)
                report("reject_reason", v.reject_reason, want);
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_ready;
    item_t    item = '0;
    logic     verdict_valid;
    logic     verdict_ready = 1'b0;
    verdict_t verdict;

    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;
    int cycle_count = 0;
    logic [7:0] str_buf[$];
    traversal_screen_model screen;

    path_traversal_screen u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            verdict_ready <= 1'b0;
        else
            verdict_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                screen.absorb_item(item);
            if (verdict_valid && verdict_ready)
                screen.compare_verdict(verdict);
        end
    end

    task send_item(input item_t it);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task send_string(input bit with_last);
        item_t it;
        for (int i = 0; i < str_buf.size(); i++)
        begin
            it.char_byte    = str_buf[i];
            it.last_byte    = with_last && (i == str_buf.size() - 1);
            it.empty_string = 1'b0;
            send_item(it);
        end
    endtask

    task send_empty(input bit last, input logic [7:0] c);
        item_t it;
        it.char_byte    = c;
        it.last_byte    = last;
        it.empty_string = 1'b1;
        send_item(it);
    endtask

    task wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (screen.pending() != 0)
            @(posedge clk);
    endtask

    function logic [7:0] any_case(logic [7:0] lc);
        return $urandom_range(0, 1) ? lc : lc - CASE_DELTA;
    endfunction

    function void add_token();
        case ($urandom_range(0, 15))
            0: str_buf = {str_buf, CH_DOT, CH_DOT, CH_SLASH};
            1: str_buf = {str_buf, CH_DOT, CH_DOT, CH_BSLASH};
            2: str_buf = {str_buf, CH_SLASH, CH_DOT, CH_DOT};
            3: str_buf = {str_buf, CH_PERCENT, CH_TWO,
                          any_case($urandom_range(0, 1) ? CH_LC_F : CH_LC_E)};
            4: str_buf = {str_buf, CH_PERCENT, CH_FIVE, any_case(CH_LC_C)};
            5:
            begin
                str_buf = {str_buf, CH_PERCENT, CH_TWO, CH_FIVE};
                if ($urandom_range(0, 1))
                    str_buf = {str_buf, CH_TWO,
                               any_case($urandom_range(0, 1) ? CH_LC_F : CH_LC_E)};
                else
                    str_buf = {str_buf, CH_FIVE, any_case(CH_LC_C)};
            end
            6: str_buf = {str_buf, CH_PERCENT, CH_ZERO, CH_ZERO};
            7: str_buf.push_back(CH_NUL);
            8, 9: str_buf.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                case ($urandom_range(0, 7))
                    0: str_buf.push_back(CH_SLASH);
                    1: str_buf.push_back(CH_DOT);
                    2: str_buf.push_back(CH_PERCENT);
                    3: str_buf.push_back(CH_TWO);
                    4: str_buf.push_back(CH_FIVE);
                    5: str_buf.push_back(CH_ZERO);
                    6: str_buf.push_back(CH_BSLASH);
                    default: str_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
                endcase
            end
        endcase
    endfunction

    task send_random_string();
        int kind;
        int ntok;
        kind = $urandom_range(0, 99);
        str_buf.delete();
        if (kind < 5)
        begin
            send_empty($urandom_range(0, 1), 8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 15)
        begin
            ntok = $urandom_range(1, 8);
            for (int i = 0; i < ntok; i++)
                str_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 4);
            for (int i = 0; i < ntok; i++)
                add_token();
        end
        if (kind < 22)
        begin
            send_string(1'b0);
            send_empty($urandom_range(0, 1), 8'($urandom_range(0, 255)));
        end
        else
            send_string(1'b1);
        if ($urandom_range(0, 199) == 0)
            wait_drained();
    endtask

    initial
    begin
        int target;
        screen = new();
        send_idle = 33;
        recv_idle = 53;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_empty(1'b0, 8'hFF);
        send_empty(1'b1, 8'h00);
        str_buf = '{CH_DOT, CH_DOT, CH_SLASH};
        send_string(1'b1);
        str_buf = '{CH_SLASH, CH_DOT, CH_DOT};
        send_string(1'b1);
        str_buf = '{CH_DOT, CH_DOT, CH_BSLASH};
        send_string(1'b1);
        str_buf = '{CH_PERCENT, CH_TWO, CH_LC_F - CASE_DELTA};
        send_string(1'b1);
        str_buf = '{CH_PERCENT, CH_TWO, CH_FIVE, CH_TWO, CH_LC_E};
        send_string(1'b1);
        str_buf = '{CH_NUL};
        send_string(1'b1);
        str_buf = '{CH_PERCENT, CH_ZERO, CH_ZERO};
        send_string(1'b1);
        str_buf = '{8'hFF};
        send_string(1'b1);
        // empty marker after bytes already fed
        str_buf = '{CH_SLASH, CH_DOT};
        send_string(1'b0);
        send_empty(1'b0, CH_DOT);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 33;
                    recv_idle = 53;
                end
                1:
                begin
                    send_idle = 53;
                    recv_idle = 33;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            target = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < target)
                send_random_string();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (screen.errors == 0 && screen.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
